// File: rtl/core/battery_gauge_step_defines.svh
`ifndef BATTERY_GAUGE_STEP_DEFINES_SVH
`define BATTERY_GAUGE_STEP_DEFINES_SVH

// Concurrent checks, sampled on the rising clock edge and held off during reset.
`define BGS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define BGS_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: rtl/core/bgs_pkg.sv
package bgs_pkg;

	localparam int unsigned MV_W        = 13;
	localparam int unsigned TEMP_W      = 8;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned LEVEL_W     = 7;
	localparam int unsigned TENTHS_W    = 12;
	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 13;

	localparam int unsigned RING_DEPTH_DEF = 6;
	localparam int unsigned TABLE_ENTRIES  = 101;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(TABLE_ENTRIES - 1);

	localparam logic [TEMP_W-1:0] OVERHEAT_RST = 8'd45;
	localparam logic [MV_W-1:0]   OVERVOLT_RST = 13'd4250;
	localparam logic [BYTE_W-1:0] USB_OFS_RST  = 8'd25;
	localparam logic [BYTE_W-1:0] AC_OFS_RST   = 8'd80;

	// Charger state codes carried in the top byte of the status word.
	localparam logic [BYTE_W-1:0] CHG_IDLE         = 8'd0;
	localparam logic [BYTE_W-1:0] CHG_HOLD         = 8'd1;
	localparam logic [BYTE_W-1:0] CHG_AC_FIRST     = 8'd2;
	localparam logic [BYTE_W-1:0] CHG_AC_LAST_CHG  = 8'd5;
	localparam logic [BYTE_W-1:0] CHG_AC_DONE      = 8'd6;
	localparam logic [BYTE_W-1:0] CHG_AC_LAST      = 8'd7;
	localparam logic [BYTE_W-1:0] CHG_DIS_A_FIRST  = 8'd8;
	localparam logic [BYTE_W-1:0] CHG_DIS_A_LAST   = 8'd16;
	localparam logic [BYTE_W-1:0] CHG_USB_HOLD     = 8'd17;
	localparam logic [BYTE_W-1:0] CHG_USB_FIRST    = 8'd18;
	localparam logic [BYTE_W-1:0] CHG_USB_LAST_CHG = 8'd21;
	localparam logic [BYTE_W-1:0] CHG_USB_DONE     = 8'd22;
	localparam logic [BYTE_W-1:0] CHG_DIS_B_FIRST  = 8'd23;
	localparam logic [BYTE_W-1:0] CHG_DIS_B_LAST   = 8'd31;
	localparam logic [BYTE_W-1:0] CHG_STOPPED      = 8'd32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_OVERHEAT = 4'd0,
		CFG_OVERVOLT = 4'd1,
		CFG_USB_OFS  = 4'd2,
		CFG_AC_OFS   = 4'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SRC_BATTERY = 2'd0,
		SRC_USB     = 2'd1,
		SRC_AC      = 2'd2,
		SRC_INVALID = 2'd3
	} source_t;

	typedef enum logic [2:0] {
		ST_UNKNOWN      = 3'd0,
		ST_CHARGING     = 3'd1,
		ST_DISCHARGING  = 3'd2,
		ST_NOT_CHARGING = 3'd3,
		ST_FULL         = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		HL_UNKNOWN  = 2'd0,
		HL_GOOD     = 2'd1,
		HL_OVERHEAT = 2'd2,
		HL_OVERVOLT = 2'd3
	} health_t;

	typedef struct packed {
		logic               read_ok;
		logic [MV_W-1:0]    battery_mv;
		logic [WORD_W-1:0]  status_word;
		logic [TEMP_W-1:0]  temp_c;
	} poll_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]  level_pct;
		logic [MV_W-1:0]     filtered_mv;
		logic [TENTHS_W-1:0] temp_tenths;
		status_t             charge_status;
		health_t             health;
		source_t             source;
		logic                ac_online;
		logic                usb_online;
		logic [BYTE_W-1:0]   present_byte;
		logic [BYTE_W-1:0]   charge_enable_byte;
		logic                offline_charge;
	} result_t;

	localparam logic [MV_W-1:0] VOLT_ROM [TABLE_ENTRIES] = '{
		13'd3521, 13'd3544, 13'd3573, 13'd3576, 13'd3582,
		13'd3586, 13'd3592, 13'd3598, 13'd3604, 13'd3610,
		13'd3618, 13'd3625, 13'd3630, 13'd3634, 13'd3640,
		13'd3646, 13'd3652, 13'd3654, 13'd3658, 13'd3662,
		13'd3665, 13'd3669, 13'd3672, 13'd3676, 13'd3678,
		13'd3680, 13'd3681, 13'd3684, 13'd3688, 13'd3689,
		13'd3692, 13'd3692, 13'd3693, 13'd3697, 13'd3699,
		13'd3700, 13'd3703, 13'd3707, 13'd3709, 13'd3710,
		13'd3715, 13'd3717, 13'd3720, 13'd3724, 13'd3727,
		13'd3730, 13'd3732, 13'd3737, 13'd3738, 13'd3733,
		13'd3748, 13'd3750, 13'd3752, 13'd3758, 13'd3762,
		13'd3767, 13'd3772, 13'd3775, 13'd3781, 13'd3786,
		13'd3789, 13'd3795, 13'd3800, 13'd3804, 13'd3810,
		13'd3815, 13'd3822, 13'd3826, 13'd3836, 13'd3841,
		13'd3845, 13'd3855, 13'd3861, 13'd3865, 13'd3873,
		13'd3880, 13'd3887, 13'd3893, 13'd3905, 13'd3909,
		13'd3915, 13'd3926, 13'd3935, 13'd3942, 13'd3949,
		13'd3960, 13'd3964, 13'd3976, 13'd3985, 13'd3992,
		13'd4002, 13'd4010, 13'd4020, 13'd4027, 13'd4040,
		13'd4048, 13'd4060, 13'd4071, 13'd4081, 13'd4100,
		13'd4134
	};

	function automatic logic [MV_W-1:0] rom_mid(input int unsigned i);
		logic [MV_W:0] s;
		s = {1'b0, VOLT_ROM[i]} + {1'b0, VOLT_ROM[i + 1]};
		return s[MV_W:1];
	endfunction

	function automatic source_t source_of(input logic [BYTE_W-1:0] chg, input logic present);
		source_t src;
		case (chg) inside
			[CHG_AC_FIRST:CHG_AC_LAST]: src = SRC_AC;
			[CHG_USB_FIRST:CHG_USB_DONE]: src = SRC_USB;
			default: src = present ? SRC_BATTERY : SRC_INVALID;
		endcase
		return src;
	endfunction

	function automatic status_t state_status(input logic [BYTE_W-1:0] chg);
		status_t st;
		case (chg) inside
			[CHG_AC_FIRST:CHG_AC_LAST_CHG], CHG_AC_LAST,
			[CHG_USB_FIRST:CHG_USB_LAST_CHG]: st = ST_CHARGING;
			CHG_IDLE, CHG_HOLD, CHG_USB_HOLD, CHG_STOPPED: st = ST_NOT_CHARGING;
			CHG_AC_DONE, CHG_USB_DONE: st = ST_FULL;
			[CHG_DIS_A_FIRST:CHG_DIS_A_LAST],
			[CHG_DIS_B_FIRST:CHG_DIS_B_LAST]: st = ST_DISCHARGING;
			default: st = ST_UNKNOWN;
		endcase
		return st;
	endfunction

endpackage

// File: rtl/core/bgs_poll_if.sv
interface bgs_poll_if;
	import bgs_pkg::*;

	logic  valid;
	logic  ready;
	poll_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/bgs_result_if.sv
interface bgs_result_if;
	import bgs_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/bgs_cfg_if.sv
interface bgs_cfg_if;
	import bgs_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/battery_gauge_step.sv
// Battery fuel gauge, one poll request in and at most one result request out.
// The poll channel carries the voltage sample, the packed status word and the
// temperature; a poll with read_ok low is taken and dropped without a trace.
// The result channel carries level, filtered voltage and the status flags.
// The configuration channel is always ready and writes one limit or offset
// register per request; an index past the last register is ignored. The
// user must see that it is written only while no poll is in flight; the block does not enforce it.
// A result is registered in the input stage and then in the result register:
// the input stage holds the poll while the mean over RING_DEPTH samples and
// the ROM search are evaluated from it, then the result register holds the
// outcome. One poll is taken every cycle while the result side does not stall.
// When the receiver stalls, the result register holds and the input stage
// still takes one more poll; the poll channel then drops ready until the
// result is taken. The charge offset follows the last read_ok poll's source.
// Reset clears the ring pointer, fill flag, last charger state and the
// pipeline valid flags, and loads the register defaults. No clearing pass is
// needed; the ring is read only once it has been filled.
`include "battery_gauge_step_defines.svh"

module battery_gauge_step #(
	parameter int unsigned RING_DEPTH = bgs_pkg::RING_DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	bgs_poll_if.sink      poll,
	bgs_result_if.source  result,
	bgs_cfg_if.sink       cfg
);
	import bgs_pkg::*;

	localparam int unsigned IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned SUM_W   = MV_W + $clog2(RING_DEPTH);
	localparam int unsigned SHIFT   = SUM_W + $clog2(RING_DEPTH);
	localparam int unsigned RECIP_W = SUM_W + 2;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

	logic [TEMP_W-1:0] overheat_q;
	logic [MV_W-1:0]   overvolt_q;
	logic [BYTE_W-1:0] usb_ofs_q;
	logic [BYTE_W-1:0] ac_ofs_q;

	logic [MV_W-1:0]   ring_q [RING_DEPTH];
	logic [IDX_W-1:0]  ring_idx_q;
	logic              filled_q;
	logic [BYTE_W-1:0] last_chg_q;
	logic              last_present_q;

	logic              valid_s1;
	logic [MV_W-1:0]   mv_s1;
	logic [WORD_W-1:0] word_s1;
	logic [TEMP_W-1:0] temp_s1;
	logic              warm_s1;
	logic [BYTE_W-1:0] offset_s1;

	logic              out_valid_q;
	result_t           res_q;

	logic              out_free;
	logic              poll_acc;
	logic              take;
	source_t           prev_src;
	logic [BYTE_W-1:0] offset_next;
	logic [IDX_W-1:0]  idx_next;

	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;
	logic [MV_W-1:0]   filt;
	logic [MV_W-1:0]   corr;
	logic [TABLE_ENTRIES-2:0] hit;
	logic [LEVEL_W-1:0] level;
	logic [BYTE_W-1:0] en_b;
	logic [BYTE_W-1:0] poc_b;
	logic [BYTE_W-1:0] pres_b;
	logic [BYTE_W-1:0] chg_b;
	source_t           src;
	status_t           status;
	health_t           health;
	result_t           res_next;

	// Input side
	assign out_free   = !out_valid_q || result.ready;
	assign poll.ready = !valid_s1 || out_free;
	assign poll_acc   = poll.valid && poll.ready;
	assign take       = poll_acc && poll.data.read_ok;
	assign cfg.ready  = 1'b1;

	assign prev_src = source_of(last_chg_q, last_present_q);
	assign offset_next = (prev_src == SRC_USB) ? usb_ofs_q :
		(prev_src == SRC_AC) ? ac_ofs_q : '0;
	assign idx_next = (ring_idx_q == IDX_W'(RING_DEPTH - 1)) ? '0 : ring_idx_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overheat_q <= OVERHEAT_RST;
			overvolt_q <= OVERVOLT_RST;
			usb_ofs_q  <= USB_OFS_RST;
			ac_ofs_q   <= AC_OFS_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_OVERHEAT: overheat_q <= cfg.data[TEMP_W-1:0];
				CFG_OVERVOLT: overvolt_q <= cfg.data[MV_W-1:0];
				CFG_USB_OFS:  usb_ofs_q  <= cfg.data[BYTE_W-1:0];
				CFG_AC_OFS:   ac_ofs_q   <= cfg.data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_idx_q     <= '0;
			filled_q       <= 1'b0;
			last_chg_q     <= CHG_IDLE;
			last_present_q <= 1'b0;
			valid_s1       <= 1'b0;
		end else begin
			if (take) begin
				ring_idx_q     <= idx_next;
				last_chg_q     <= poll.data.status_word[31:24];
				last_present_q <= |poll.data.status_word[23:16];
				if (idx_next == '0) begin
					filled_q <= 1'b1;
				end
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ring_q[ring_idx_q] <= poll.data.battery_mv;
			mv_s1     <= poll.data.battery_mv;
			word_s1   <= poll.data.status_word;
			temp_s1   <= poll.data.temp_c;
			warm_s1   <= !filled_q;
			offset_s1 <= offset_next;
		end
	end

	// Filter, offset correction and ROM search
	always_comb begin
		sum = '0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			sum = sum + SUM_W'(ring_q[i]);
		end
	end

	assign prod = {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP};
	assign filt = warm_s1 ? mv_s1 : prod[SHIFT +: MV_W];
	assign corr = (filt > MV_W'(offset_s1)) ? filt - MV_W'(offset_s1) : '0;

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
			hit[i] = (corr >= VOLT_ROM[i]) && (corr <= VOLT_ROM[i + 1]);
		end
	end

	always_comb begin
		level = '0;
		if (corr >= VOLT_ROM[TABLE_ENTRIES - 1]) begin
			level = LEVEL_MAX;
		end else if (corr > VOLT_ROM[0]) begin
			// The lowest matching interval wins, so scan from the top down.
			for (int i = TABLE_ENTRIES - 2; i >= 0; i--) begin
				if (hit[i]) begin
					level = (corr <= rom_mid(i)) ? LEVEL_W'(i) : LEVEL_W'(i + 1);
				end
			end
		end
	end

	assign en_b   = word_s1[7:0];
	assign poc_b  = word_s1[15:8];
	assign pres_b = word_s1[23:16];
	assign chg_b  = word_s1[31:24];
	assign src    = source_of(chg_b, |pres_b);

	always_comb begin
		status = state_status(chg_b);
		if ((src == SRC_USB || src == SRC_AC) && level == LEVEL_MAX) begin
			status = ST_FULL;
		end
		if (pres_b == '0) begin
			health = HL_UNKNOWN;
		end else if (temp_s1 > overheat_q) begin
			health = HL_OVERHEAT;
		end else if (filt > overvolt_q) begin
			health = HL_OVERVOLT;
		end else begin
			health = HL_GOOD;
		end
	end

	always_comb begin
		res_next.level_pct          = level;
		res_next.filtered_mv        = filt;
		res_next.temp_tenths        = (TENTHS_W'(temp_s1) << 3) + (TENTHS_W'(temp_s1) << 1);
		res_next.charge_status      = status;
		res_next.health             = health;
		res_next.source             = src;
		res_next.ac_online          = (src == SRC_AC);
		res_next.usb_online         = (src == SRC_USB);
		res_next.present_byte       = pres_b;
		res_next.charge_enable_byte = en_b;
		res_next.offline_charge     = (poc_b == 8'd1) && (en_b == 8'd1);
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			res_q <= res_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	`BGS_ASSERT(a_drop_keeps_state,
		(poll.valid && poll.ready && !poll.data.read_ok) |=>
		($stable(ring_idx_q) && $stable(last_chg_q) && $stable(filled_q)),
		"dropped poll changed gauge state")
	`BGS_ASSERT(a_idx_in_range, ring_idx_q <= IDX_W'(RING_DEPTH - 1), "ring pointer out of range")
	`BGS_ASSERT(a_full_at_top,
		(result.valid && (result.data.source == SRC_USB || result.data.source == SRC_AC)
		&& result.data.level_pct == LEVEL_MAX) |-> (result.data.charge_status == ST_FULL),
		"charging at full level not reported full")
	`BGS_ASSERT_NEVER(a_filled_sticks, $fell(filled_q), "ring fill flag cleared after fill")

endmodule
